// ----- src/prescaled_down_counter_timer_unit_macros.svh -----
// Assertion helpers used by the timer core RTL.
`ifndef PRESCALED_DOWN_COUNTER_TIMER_UNIT_MACROS_SVH
`define PRESCALED_DOWN_COUNTER_TIMER_UNIT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define PDCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define PDCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- src/pdct_pkg.sv -----
`default_nettype none

package pdct_pkg;

    localparam int DATA_W      = 32;
    localparam int OFFSET_W    = 12;
    localparam int KIND_W      = 2;
    localparam int CTRL_W      = 3;
    localparam int COUNTER_W   = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    // Register byte offsets
    localparam logic [OFFSET_W-1:0] OFF_LOAD      = 12'h000;
    localparam logic [OFFSET_W-1:0] OFF_VALUE     = 12'h004;
    localparam logic [OFFSET_W-1:0] OFF_CTRL      = 12'h008;
    localparam logic [OFFSET_W-1:0] OFF_INTSTAT   = 12'h00C;
    localparam logic [OFFSET_W-1:0] OFF_PRESCALER = 12'h010;

    // CTRL bit positions
    localparam int CB_ENABLE  = 0;
    localparam int CB_IRQ_EN  = 1;
    localparam int CB_ONESHOT = 2;

    typedef struct packed {
        logic                act;
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] byte_offset;
        logic [DATA_W-1:0]   write_data;
    } t_core_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
    } t_core_rsp;

endpackage

`default_nettype wire

// ----- src/pdct_item_if.sv -----
`default_nettype none

interface pdct_item_if;
    import pdct_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] byte_offset;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, output kind, output byte_offset, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input byte_offset, input write_data,
                    output ready);
endinterface

`default_nettype wire

// ----- src/pdct_result_if.sv -----
`default_nettype none

interface pdct_result_if;
    import pdct_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_level;

    modport source (output valid, output read_data, output irq_level, input ready);
    modport sink   (input valid, input read_data, input irq_level, output ready);
endinterface

`default_nettype wire

// ----- src/pdct_core.sv -----
`default_nettype none

module pdct_core #(
    parameter int COUNTER_WIDTH = pdct_pkg::COUNTER_W
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pdct_pkg::t_core_req i_req,
    output pdct_pkg::t_core_rsp o_rsp
);
    import pdct_pkg::*;

    logic [COUNTER_WIDTH-1:0] r_load,   n_load;
    logic [COUNTER_WIDTH-1:0] r_cnt,    n_cnt;
    logic [CTRL_W-1:0]        r_ctrl,   n_ctrl;
    logic                     r_fired,  n_fired;
    logic [DATA_W-1:0]        r_pset,   n_pset;
    logic [DATA_W-1:0]        r_pcnt,   n_pcnt;

    logic                     counting;
    logic [COUNTER_WIDTH-1:0] cnt_dec;
    logic [DATA_W-1:0]        rd;

    assign counting = r_ctrl[CB_ENABLE] && (r_load != '0);
    assign cnt_dec  = r_cnt - COUNTER_WIDTH'(1);

    always_comb begin
        n_load  = r_load;
        n_cnt   = r_cnt;
        n_ctrl  = r_ctrl;
        n_fired = r_fired;
        n_pset  = r_pset;
        n_pcnt  = r_pcnt;
        rd      = '0;

        if (i_req.act) begin
            unique case (i_req.kind)
                KIND_TICK: begin
                    if (counting) begin
                        if (r_pcnt != r_pset) begin
                            n_pcnt = r_pcnt + DATA_W'(1);
                        end else begin
                            n_pcnt = '0;
                            if (cnt_dec == '0) begin
                                n_fired = 1'b1;
                                if (r_ctrl[CB_ONESHOT]) begin
                                    n_ctrl[CB_ENABLE] = 1'b0;
                                    n_cnt = cnt_dec;
                                end else begin
                                    n_cnt = r_load;
                                end
                            end else begin
                                n_cnt = cnt_dec;
                            end
                        end
                    end
                end
                KIND_READ: begin
                    unique case (i_req.byte_offset)
                        OFF_LOAD:      rd = DATA_W'(r_load);
                        OFF_VALUE:     rd = counting ? DATA_W'(r_cnt) : '0;
                        OFF_CTRL:      rd = DATA_W'(r_ctrl);
                        OFF_INTSTAT:   rd = DATA_W'(r_fired);
                        OFF_PRESCALER: rd = r_pset;
                        default:       rd = '0;
                    endcase
                end
                KIND_WRITE: begin
                    unique case (i_req.byte_offset)
                        OFF_LOAD: begin
                            n_load = i_req.write_data[COUNTER_WIDTH-1:0];
                            if (r_ctrl[CB_ENABLE]) begin
                                n_cnt  = i_req.write_data[COUNTER_WIDTH-1:0];
                                n_pcnt = '0;
                            end
                        end
                        OFF_CTRL: begin
                            n_ctrl = i_req.write_data[CTRL_W-1:0];
                            // rising enable restarts the count
                            if (i_req.write_data[CB_ENABLE] && !r_ctrl[CB_ENABLE]) begin
                                n_cnt  = r_load;
                                n_pcnt = '0;
                            end
                        end
                        OFF_INTSTAT: begin
                            n_fired = r_fired & ~i_req.write_data[0];
                        end
                        OFF_PRESCALER: begin
                            n_pset = i_req.write_data;
                            if (r_ctrl[CB_ENABLE]) begin
                                n_cnt  = r_load;
                                n_pcnt = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.read_data = rd;
    assign o_rsp.irq_level = n_ctrl[CB_IRQ_EN] & n_fired;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '0;
            r_cnt   <= '0;
            r_ctrl  <= '0;
            r_fired <= 1'b0;
            r_pset  <= '0;
            r_pcnt  <= '0;
        end else begin
            r_load  <= n_load;
            r_cnt   <= n_cnt;
            r_ctrl  <= n_ctrl;
            r_fired <= n_fired;
            r_pset  <= n_pset;
            r_pcnt  <= n_pcnt;
        end
    end

`include "prescaled_down_counter_timer_unit_macros.svh"

    `PDCT_ASSERT(a_fire_on_tick, $rose(r_fired) |-> $past(i_req.act && i_req.kind == KIND_TICK), "fired set without a tick")
    `PDCT_ASSERT(a_enable_by_write, $rose(r_ctrl[CB_ENABLE]) |-> $past(i_req.act && i_req.kind == KIND_WRITE && i_req.byte_offset == OFF_CTRL), "enable set without a CTRL write")
    `PDCT_ASSERT(a_enable_drop, $fell(r_ctrl[CB_ENABLE]) |-> ($past(i_req.act && i_req.kind == KIND_WRITE && i_req.byte_offset == OFF_CTRL) || r_fired), "enable cleared without write or expiry")

endmodule

`default_nettype wire

// ----- src/prescaled_down_counter_timer_unit.sv -----
// Channel   Dir   Payload                              Accepted when
// i_item    in    kind, byte_offset, write_data        valid && ready
// o_result  out   read_data, irq_level                 valid && ready
//
// An accepted item sits in the input register while the update logic works on it; its
// result is loaded into the output register and offered once that register can advance.
// One item per cycle is sustained while the result side takes results.
// A stalled result holds the output register; one more item waits in the input register.
// Reset (synchronous, active low) clears all timer registers and both valid flags.
`default_nettype none

module prescaled_down_counter_timer_unit #(
    parameter int COUNTER_WIDTH = pdct_pkg::COUNTER_W
) (
    input wire          i_clk,
    input wire          i_rst_n,
    pdct_item_if.sink   i_item,
    pdct_result_if.source o_result
);
    import pdct_pkg::*;

    logic                r_in_valid;
    logic [KIND_W-1:0]   r_in_kind;
    logic [OFFSET_W-1:0] r_in_offset;
    logic [DATA_W-1:0]   r_in_data;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_rdata;
    logic                r_out_irq;

    logic      adv;
    t_core_req req;
    t_core_rsp rsp;

    assign adv          = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_in_valid || adv;

    assign req.act         = r_in_valid && adv;
    assign req.kind        = r_in_kind;
    assign req.byte_offset = r_in_offset;
    assign req.write_data  = r_in_data;

    pdct_core #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_kind   <= i_item.kind;
            r_in_offset <= i_item.byte_offset;
            r_in_data   <= i_item.write_data;
        end
        if (req.act) begin
            r_out_rdata <= rsp.read_data;
            r_out_irq   <= rsp.irq_level;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.read_data = r_out_rdata;
    assign o_result.irq_level = r_out_irq;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
module tb_top;
    import pdct_pkg::*;

    // kind 3 is decoded as a no-op by the timer
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
    localparam int TMR_W = COUNTER_W;
    localparam logic [DATA_W-1:0] CNT_MASK = DATA_W'((64'd1 << TMR_W) - 64'd1);
    localparam int ITEM_TARGET = 1600;
    localparam int PHASE_LEN = 200;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] byte_offset;
        logic [DATA_W-1:0]   write_data;
        bit                  drain;      // hold this item until all results are back
    } t_bus_item;

    logic i_clk;
    logic i_rst_n;

    pdct_item_if   item_ch();
    pdct_result_if res_ch();

    prescaled_down_counter_timer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(res_ch)
    );

    // timer state as the predictor sees it
    logic [DATA_W-1:0] m_load;
    logic [CTRL_W-1:0] m_ctrl;
    logic              m_fired;
    logic [DATA_W-1:0] m_psc;
    logic [DATA_W-1:0] m_pcnt;
    logic [DATA_W-1:0] m_cnt;

    t_bus_item bus_items[$];
    t_core_rsp pending_rsp[$];
    t_bus_item cur_item;
    t_core_rsp drv_rsp;
    t_core_rsp mon_rsp;

    int  n_pred;
    int  n_checked;
    int  err_cnt;
    int  n_ticks, n_reads, n_writes, n_fires;
    bit  drain_next;
    logic [1:0] phase;
    logic rx_hold;

    int tx_idle_pct[4]  = '{0, 60, 0, 21};
    int rx_stall_pct[4] = '{0, 0, 60, 21};
    logic [OFFSET_W-1:0] reg_offsets[5] = '{OFF_LOAD, OFF_VALUE, OFF_CTRL, OFF_INTSTAT,
                                            OFF_PRESCALER};

    function automatic bit timer_running();
        return m_ctrl[CB_ENABLE] && (m_load != '0);
    endfunction

    function automatic void timer_restart();
        m_cnt  = m_load;
        m_pcnt = '0;
    endfunction

    // Applies one item to the predicted timer state and returns the expected result.
    function automatic t_core_rsp advance_timer(t_bus_item it);
        t_core_rsp r;
        logic [CTRL_W-1:0] old_ctrl;
        r.read_data = '0;
        case (it.kind)
            KIND_TICK: begin
                if (timer_running()) begin
                    if (m_pcnt != m_psc) begin
                        m_pcnt = m_pcnt + 1;
                    end else begin
                        m_pcnt = '0;
                        m_cnt  = (m_cnt - 1) & CNT_MASK;
                        if (m_cnt == '0) begin
                            m_fired = 1'b1;
                            n_fires++;
                            if (m_ctrl[CB_ONESHOT]) m_ctrl[CB_ENABLE] = 1'b0;
                            else m_cnt = m_load;
                        end
                    end
                end
            end
            KIND_READ: begin
                case (it.byte_offset)
                    OFF_LOAD:      r.read_data = m_load;
                    OFF_VALUE:     r.read_data = timer_running() ? m_cnt : '0;
                    OFF_CTRL:      r.read_data = DATA_W'(m_ctrl);
                    OFF_INTSTAT:   r.read_data = DATA_W'(m_fired);
                    OFF_PRESCALER: r.read_data = m_psc;
                    default:       r.read_data = '0;
                endcase
            end
            KIND_WRITE: begin
                case (it.byte_offset)
                    OFF_LOAD: begin
                        m_load = it.write_data & CNT_MASK;
                        if (m_ctrl[CB_ENABLE]) timer_restart();
                    end
                    OFF_CTRL: begin
                        old_ctrl = m_ctrl;
                        m_ctrl   = it.write_data[CTRL_W-1:0];
                        if (m_ctrl[CB_ENABLE] && !old_ctrl[CB_ENABLE]) timer_restart();
                    end
                    OFF_INTSTAT: m_fired = m_fired & ~it.write_data[0];
                    OFF_PRESCALER: begin
                        m_psc = it.write_data;
                        if (m_ctrl[CB_ENABLE]) timer_restart();
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.irq_level = m_ctrl[CB_IRQ_EN] & m_fired;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (err_cnt < 50) $display("MISMATCH result %0d: %s", n_checked, msg);
        err_cnt++;
    endtask

    task automatic add_item(logic [KIND_W-1:0] kind, logic [OFFSET_W-1:0] off,
                            logic [DATA_W-1:0] data);
        t_bus_item it;
        it.kind        = kind;
        it.byte_offset = off;
        it.write_data  = data;
        it.drain       = drain_next || (bus_items.size() % 400 == 399);
        drain_next     = 1'b0;
        bus_items.push_back(it);
    endtask

    task automatic add_noise();
        logic [OFFSET_W-1:0] off;
        off = $urandom_range(0, 1) ? OFFSET_W'($urandom())
                                   : OFFSET_W'(reg_offsets[$urandom_range(0, 4)]
                                               + $urandom_range(0, 3));
        add_item(KIND_W'($urandom_range(0, 3)), off, $urandom());
    endtask

    function automatic logic [DATA_W-1:0] small_load();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return $urandom();
        return $urandom_range(1, 6);
    endfunction

    function automatic logic [DATA_W-1:0] small_psc();
        return ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 3);
    endfunction

    // Set up a count, usually start it and let it run with register traffic mixed in.
    task automatic add_timer_burst();
        logic [DATA_W-1:0] ctrl;
        int r;
        if ($urandom_range(0, 1)) add_item(KIND_WRITE, OFF_CTRL, '0);
        add_item(KIND_WRITE, OFF_PRESCALER, small_psc());
        add_item(KIND_WRITE, OFF_LOAD, small_load());
        ctrl = $urandom();
        ctrl[CB_ENABLE] = ($urandom_range(0, 5) != 0);
        add_item(KIND_WRITE, OFF_CTRL, ctrl);
        repeat ($urandom_range(5, 40)) begin
            r = $urandom_range(0, 99);
            if (r < 65) add_item(KIND_TICK, OFFSET_W'($urandom()), $urandom());
            else if (r < 80) add_item(KIND_READ, reg_offsets[$urandom_range(0, 4)], $urandom());
            else if (r < 86) add_item(KIND_WRITE, OFF_INTSTAT, $urandom());
            else if (r < 90) add_item(KIND_WRITE, OFF_CTRL, $urandom());
            else if (r < 93) add_item(KIND_WRITE, OFF_LOAD, small_load());
            else if (r < 96) add_item(KIND_WRITE, OFF_PRESCALER, small_psc());
            else add_noise();
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                drv_rsp = advance_timer(cur_item);
                pending_rsp.push_back(drv_rsp);
                n_pred++;
                if (cur_item.kind == KIND_TICK) n_ticks++;
                else if (cur_item.kind == KIND_READ) n_reads++;
                else if (cur_item.kind == KIND_WRITE) n_writes++;
            end
            if (item_ch.valid && !item_ch.ready) begin
                // hold the offered item
            end else if (bus_items.size() != 0 && !(bus_items[0].drain && n_checked != n_pred)
                         && !(tx_idle_pct[phase] != 0
                              && $urandom_range(0, 99) < tx_idle_pct[phase])) begin
                cur_item = bus_items.pop_front();
                item_ch.valid       <= 1'b1;
                item_ch.kind        <= cur_item.kind;
                item_ch.byte_offset <= cur_item.byte_offset;
                item_ch.write_data  <= cur_item.write_data;
            end else begin
                item_ch.valid <= 1'b0;
            end
            phase <= 2'((n_pred / PHASE_LEN) % 4);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    mon_rsp = pending_rsp.pop_front();
                    if (res_ch.read_data !== mon_rsp.read_data)
                        report_mismatch($sformatf("read_data got %h exp %h",
                                                  res_ch.read_data, mon_rsp.read_data));
                    if (res_ch.irq_level !== mon_rsp.irq_level)
                        report_mismatch($sformatf("irq_level got %b exp %b",
                                                  res_ch.irq_level, mon_rsp.irq_level));
                    n_checked <= n_checked + 1;
                end
            end
            res_ch.ready <= !rx_hold && !(rx_stall_pct[phase] != 0
                                          && $urandom_range(0, 99) < rx_stall_pct[phase]);
        end
    end

    // long result-side hold-off so the timer backs up and stalls its input
    initial begin
        rx_hold = 1'b0;
        wait (n_pred >= 300);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (60) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        item_ch.valid       = 1'b0;
        item_ch.kind        = KIND_TICK;
        item_ch.byte_offset = '0;
        item_ch.write_data  = '0;
        res_ch.ready        = 1'b0;
        i_rst_n    = 1'b0;
        phase      = '0;
        n_pred     = 0;
        n_checked  = 0;
        err_cnt    = 0;
        n_ticks    = 0;
        n_reads    = 0;
        n_writes   = 0;
        n_fires    = 0;
        drain_next = 1'b0;
        m_load  = '0;
        m_ctrl  = '0;
        m_fired = 1'b0;
        m_psc   = '0;
        m_pcnt  = '0;
        m_cnt   = '0;

        // registers straight out of reset
        foreach (reg_offsets[i]) add_item(KIND_READ, reg_offsets[i], '1);
        // largest load and prescaler: the prescaler must not wrap, so no decrement
        add_item(KIND_WRITE, OFF_LOAD, '1);
        add_item(KIND_WRITE, OFF_PRESCALER, '1);
        add_item(KIND_WRITE, OFF_CTRL, '1);
        add_item(KIND_TICK, '0, '0);
        add_item(KIND_TICK, '1, '1);
        add_item(KIND_READ, OFF_VALUE, '0);
        // zero load stops the count while enabled
        add_item(KIND_WRITE, OFF_LOAD, '0);
        add_item(KIND_TICK, '0, '0);
        add_item(KIND_READ, OFF_VALUE, '0);
        // short one-shot, prescale by two
        add_item(KIND_WRITE, OFF_PRESCALER, 32'd1);
        add_item(KIND_WRITE, OFF_LOAD, 32'd2);
        add_item(KIND_WRITE, OFF_CTRL, 32'h7);   // enable already set: no restart
        repeat (4) add_item(KIND_TICK, '0, '0);
        add_item(KIND_READ, OFF_CTRL, '0);
        add_item(KIND_READ, OFF_INTSTAT, '0);
        add_item(KIND_WRITE, OFF_VALUE, '1);
        add_item(KIND_WRITE, OFF_INTSTAT, '1);
        add_item(KIND_READ, 12'h002, '0);
        add_item(KIND_WRITE, 12'hFFC, '1);
        add_item(KIND_NOP, OFF_LOAD, '1);

        drain_next = 1'b1;
        while (bus_items.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 4) != 0) add_timer_burst();
            else repeat ($urandom_range(1, 5)) add_noise();
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bus_items.size() != 0 || item_ch.valid) @(posedge i_clk);
        while (n_checked != n_pred) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (pending_rsp.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_rsp.size()));

        $display("Run covered %0d items: %0d ticks, %0d reads, %0d writes, %0d other.",
                 n_pred, n_ticks, n_reads, n_writes, n_pred - n_ticks - n_reads - n_writes);
        $display("Timer expired %0d times; %0d results checked under idle and stall phases.",
                 n_fires, n_checked);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
